/* rtl/wcpr_pkg.sv */
// Package for the waveform column peak/RMS block.
// Holds the payload, queue entry and configuration types and the shared widths.
// No dependencies.
`default_nettype none

package wcpr_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int COLUMN_BITS  = 12;
	localparam int HEIGHT_BITS  = 12;
	localparam int COUNT_BITS   = 16;
	localparam int SUM_BITS     = 48;
	localparam int SQ_BITS      = 2 * SAMPLE_BITS;
	localparam int MEAN_BITS    = 2 * SAMPLE_BITS;
	localparam int ROOT_BITS    = SAMPLE_BITS;
	localparam int NUM_BITS     = SAMPLE_BITS + 1;
	localparam int CFG_DATA_BITS = 16;
	localparam int QUEUE_DEPTH  = 4;

	typedef enum logic [1:0] {
		CFG_SAMPLES_PER_COLUMN = 2'd0,
		CFG_PIXEL_HEIGHT       = 2'd1,
		CFG_FIRST_COLUMN       = 2'd2,
		CFG_LAST_COLUMN        = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          start_req;
	} sample_t;

	typedef struct packed {
		logic [COLUMN_BITS-1:0] column;
		logic [HEIGHT_BITS-1:0] peak_top_y;
		logic [HEIGHT_BITS-1:0] peak_bottom_y;
		logic [HEIGHT_BITS-1:0] rms_top_y;
		logic [HEIGHT_BITS-1:0] rms_bottom_y;
	} result_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0]  samples_per_column;
		logic [HEIGHT_BITS-1:0] pixel_height;
		logic [COLUMN_BITS-1:0] first_column;
		logic [COLUMN_BITS-1:0] last_column;
	} cfg_t;

	// one finished column waiting for the back end
	typedef struct packed {
		logic [COLUMN_BITS-1:0]        column;
		logic signed [SAMPLE_BITS-1:0] peak_max;
		logic signed [SAMPLE_BITS-1:0] peak_min;
		logic [SUM_BITS-1:0]           square_sum;
	} column_t;

	// zero samples per column behaves as one
	function automatic logic [COUNT_BITS-1:0] eff_spc(input logic [COUNT_BITS-1:0] spc);
		eff_spc = (spc == '0) ? COUNT_BITS'(1) : spc;
	endfunction

endpackage

`default_nettype wire

/* rtl/wcpr_front.sv */
// Front end: input register with squaring, then per-column accumulators.
// Pushes one column_t word into the queue when a column completes.
// Depends on wcpr_pkg.
`default_nettype none

module wcpr_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wcpr_pkg::cfg_t     cfg,
	input  wire logic               sample_valid,
	output logic                    sample_stall,
	input  wire wcpr_pkg::sample_t  sample_data,
	input  wire logic               full,
	output logic                    push,
	output wcpr_pkg::column_t       push_data
);

	localparam int SB = wcpr_pkg::SAMPLE_BITS;
	localparam int CB = wcpr_pkg::COUNT_BITS;

	logic                             valid_s1;
	logic signed [SB-1:0]             sample_s1;
	logic                             start_s1;
	logic [wcpr_pkg::SQ_BITS-1:0]     sq_s1;

	logic signed [SB-1:0]             s_in;
	logic signed [wcpr_pkg::SQ_BITS-1:0] sq_full;

	logic [CB-1:0]                    count_q;
	logic [wcpr_pkg::COLUMN_BITS-1:0] col_q;
	logic signed [SB-1:0]             max_q;
	logic signed [SB-1:0]             min_q;
	logic [wcpr_pkg::SUM_BITS-1:0]    sum_q;
	logic                             past_end_q;

	logic                             advance;
	logic                             accept;
	logic                             pe;
	logic [wcpr_pkg::COLUMN_BITS-1:0] col_b;
	logic [CB-1:0]                    count_b;
	logic signed [SB-1:0]             max_b;
	logic signed [SB-1:0]             min_b;
	logic [wcpr_pkg::SUM_BITS-1:0]    sum_b;
	logic signed [SB-1:0]             max_n;
	logic signed [SB-1:0]             min_n;
	logic [wcpr_pkg::SUM_BITS-1:0]    sum_n;
	logic [CB:0]                      count_n;
	logic                             done;

	assign s_in    = sample_data.sample;
	assign sq_full = s_in * s_in;

	// hold the sample in s1 while the queue is full
	assign advance      = valid_s1 && !full;
	assign sample_stall = valid_s1 && full;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= s_in;
			start_s1  <= sample_data.start_req;
			sq_s1     <= sq_full;
		end
	end

	always_comb begin
		if (start_s1) begin
			pe      = cfg.first_column > cfg.last_column;
			col_b   = cfg.first_column;
			count_b = '0;
			max_b   = '0;
			min_b   = '0;
			sum_b   = '0;
		end else begin
			pe      = past_end_q;
			col_b   = col_q;
			count_b = count_q;
			max_b   = max_q;
			min_b   = min_q;
			sum_b   = sum_q;
		end
		max_n = max_b;
		min_n = min_b;
		if (sample_s1 > max_b) begin
			max_n = sample_s1;
		end else if (sample_s1 < min_b) begin
			min_n = sample_s1;
		end
		sum_n   = sum_b + wcpr_pkg::SUM_BITS'(sq_s1);
		count_n = {1'b0, count_b} + (CB+1)'(1);
		done    = count_n >= {1'b0, wcpr_pkg::eff_spc(cfg.samples_per_column)};
	end

	assign push              = advance && !pe && done;
	assign push_data.column  = col_b;
	assign push_data.peak_max = max_n;
	assign push_data.peak_min = min_n;
	assign push_data.square_sum = sum_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			col_q      <= '0;
			max_q      <= '0;
			min_q      <= '0;
			sum_q      <= '0;
			past_end_q <= 1'b1;
		end else if (advance) begin
			past_end_q <= pe;
			col_q      <= col_b;
			count_q    <= count_b;
			max_q      <= max_b;
			min_q      <= min_b;
			sum_q      <= sum_b;
			if (!pe) begin
				if (done) begin
					count_q <= '0;
					max_q   <= '0;
					min_q   <= '0;
					sum_q   <= '0;
					// stop after the last column, else advance
					if (col_b == cfg.last_column) begin
						past_end_q <= 1'b1;
					end else begin
						col_q <= col_b + wcpr_pkg::COLUMN_BITS'(1);
					end
				end else begin
					count_q <= count_n[CB-1:0];
					max_q   <= max_n;
					min_q   <= min_n;
					sum_q   <= sum_n;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/wcpr_queue.sv */
// Short FIFO of finished columns between the front and back ends.
// Register array, one write and one read address per cycle.
// Depends on wcpr_pkg.
`default_nettype none

module wcpr_queue #(
	parameter int DEPTH = wcpr_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire wcpr_pkg::column_t  push_data,
	input  wire logic               pop,
	output wcpr_pkg::column_t       head,
	output logic                    full,
	output logic                    empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	wcpr_pkg::column_t entry_q [DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [NW-1:0]     fill_q;

	assign full  = fill_q == NW'(DEPTH);
	assign empty = fill_q == '0;
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/wcpr_back.sv */
// Back end: per column, bit-serial divide of the square sum, digit-serial
// square root, four shared-multiplier pixel scalings, then the output register.
// Depends on wcpr_pkg.
`default_nettype none

module wcpr_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wcpr_pkg::cfg_t     cfg,
	input  wire logic               empty,
	input  wire wcpr_pkg::column_t  head,
	output logic                    pop,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output wcpr_pkg::result_t       result_data
);

	localparam int SB   = wcpr_pkg::SAMPLE_BITS;
	localparam int CB   = wcpr_pkg::COUNT_BITS;
	localparam int WB   = wcpr_pkg::SUM_BITS;
	localparam int RB   = wcpr_pkg::ROOT_BITS;
	localparam int MB   = wcpr_pkg::MEAN_BITS;
	localparam int NB   = wcpr_pkg::NUM_BITS;
	localparam int HB   = wcpr_pkg::HEIGHT_BITS;
	localparam int PB   = HB + NB;
	localparam int STB  = $clog2(WB);
	localparam logic [NB-1:0] FULL = NB'(1) << (SB - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_SQRT  = 5'b00100,
		ST_SCALE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                           state_q;
	logic [STB-1:0]                   cnt_q;
	logic [wcpr_pkg::COLUMN_BITS-1:0] col_q;
	logic signed [SB-1:0]             max_q;
	logic signed [SB-1:0]             min_q;
	logic [WB-1:0]                    quo_q;
	logic [CB-1:0]                    drem_q;
	logic [MB-1:0]                    rad_q;
	logic [RB:0]                      srem_q;
	logic [RB-1:0]                    root_q;
	logic [HB-1:0]                    rows_q [4];
	logic                             res_valid_q;
	wcpr_pkg::result_t                res_q;

	logic [CB-1:0]        n_eff;
	logic [CB:0]          dshift;
	logic                 dge;
	logic [CB-1:0]        drem_n;
	logic [WB-1:0]        quo_n;
	logic [RB+2:0]        sshift;
	logic [RB+2:0]        strial;
	logic                 sge;
	logic [RB:0]          srem_n;
	logic [RB-1:0]        root_n;
	logic signed [NB:0]   num_top;
	logic signed [NB:0]   num_bot;
	logic [NB-1:0]        num;
	logic [PB-1:0]        prod;
	logic [PB-SB-1:0]     row_raw;
	logic [HB-1:0]        row;
	logic                 out_free;

	assign n_eff = wcpr_pkg::eff_spc(cfg.samples_per_column);

	// restoring divide, one quotient bit a cycle
	always_comb begin
		dshift = {drem_q, quo_q[WB-1]};
		dge    = dshift >= {1'b0, n_eff};
		drem_n = dge ? CB'(dshift - {1'b0, n_eff}) : dshift[CB-1:0];
		quo_n  = {quo_q[WB-2:0], dge};
	end

	// square root, one root bit a cycle
	always_comb begin
		sshift = {srem_q, rad_q[MB-1:MB-2]};
		strial = {1'b0, root_q, 2'b01};
		sge    = sshift >= strial;
		srem_n = sge ? (RB+1)'(sshift - strial) : sshift[RB:0];
		root_n = {root_q[RB-2:0], sge};
	end

	// pixel row = height * num / 2^SAMPLE_BITS, saturated to height
	always_comb begin
		num_top = (NB+1)'(FULL) - (NB+1)'(max_q);
		num_bot = (NB+1)'(FULL) - (NB+1)'(min_q);
		case (cnt_q[1:0])
			2'd0:    num = num_top[NB-1:0];
			2'd1:    num = num_bot[NB-1:0];
			2'd2:    num = FULL - NB'(root_q);
			default: num = FULL + NB'(root_q);
		endcase
		prod    = PB'(cfg.pixel_height) * PB'(num);
		row_raw = prod[PB-1:SB];
		row     = (row_raw > (PB-SB)'(cfg.pixel_height)) ? cfg.pixel_height : row_raw[HB-1:0];
	end

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign out_free = !res_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (!empty) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == STB'(WB - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + STB'(1);
					end
				end
				ST_SQRT: begin
					if (cnt_q == STB'(RB - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SCALE;
					end else begin
						cnt_q <= cnt_q + STB'(1);
					end
				end
				ST_SCALE: begin
					if (cnt_q == STB'(3)) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + STB'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// load the output word from a finished column, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				col_q  <= head.column;
				max_q  <= head.peak_max;
				min_q  <= head.peak_min;
				quo_q  <= head.square_sum;
				drem_q <= '0;
			end
			ST_DIV: begin
				quo_q  <= quo_n;
				drem_q <= drem_n;
				// mean square fits the radicand; load it on the last bit
				rad_q  <= quo_n[MB-1:0];
				srem_q <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rad_q  <= rad_q << 2;
				srem_q <= srem_n;
				root_q <= root_n;
			end
			ST_SCALE: begin
				rows_q[cnt_q[1:0]] <= row;
			end
			ST_DONE: begin
				if (out_free) begin
					res_q.column        <= col_q;
					res_q.peak_top_y    <= rows_q[0];
					res_q.peak_bottom_y <= rows_q[1];
					res_q.rms_top_y     <= rows_q[2];
					res_q.rms_bottom_y  <= rows_q[3];
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE))
		else $error("queue popped outside idle");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised without a finished column");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (res_valid_q && state_q == ST_IDLE))
		else $error("finished column not moved to the output register");

endmodule

`default_nettype wire

/* rtl/waveform_column_peak_rms.sv */
// Waveform column peak/RMS summary, top level.
// A column's last sample passes the front-end input register and the queue, then the back
// end's divide, square root and scaling states and its output register before its result
// word is raised; it waits longer while the queue is backed up or the output is stalled.
// Throughput: one sample per cycle while the queue has room; the back end works on one
// column at a time and takes the next only once it is idle, so short columns are paced by it.
`default_nettype none

module waveform_column_peak_rms #(
	parameter int QUEUE_DEPTH = wcpr_pkg::QUEUE_DEPTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               sample_valid,
	output logic                                    sample_stall,
	input  wire wcpr_pkg::sample_t                  sample_data,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output wcpr_pkg::result_t                       result_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire wcpr_pkg::cfg_index_t               cfg_index,
	input  wire logic [wcpr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int HB = wcpr_pkg::HEIGHT_BITS;
	localparam int CB = wcpr_pkg::COLUMN_BITS;

	wcpr_pkg::cfg_t    cfg_q;
	wcpr_pkg::column_t push_data;
	wcpr_pkg::column_t head;
	logic              push;
	logic              pop;
	logic              full;
	logic              empty;

	// reset: asynchronous, active low; idle until a start word, registers at defaults
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_per_column <= wcpr_pkg::COUNT_BITS'(1);
			cfg_q.pixel_height       <= HB'(256);
			cfg_q.first_column       <= '0;
			cfg_q.last_column        <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wcpr_pkg::CFG_SAMPLES_PER_COLUMN:
					cfg_q.samples_per_column <= cfg_data[wcpr_pkg::COUNT_BITS-1:0];
				wcpr_pkg::CFG_PIXEL_HEIGHT: cfg_q.pixel_height <= cfg_data[HB-1:0];
				wcpr_pkg::CFG_FIRST_COLUMN: cfg_q.first_column <= cfg_data[CB-1:0];
				wcpr_pkg::CFG_LAST_COLUMN:  cfg_q.last_column  <= cfg_data[CB-1:0];
				default: begin
				end
			endcase
		end
	end

	wcpr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.full         (full),
		.push         (push),
		.push_data    (push_data)
	);

	wcpr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	wcpr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for waveform_column_peak_rms: drives sample and register words,
// predicts every column word in a behavioral model of its own and checks each one in order.
// Depends on wcpr_pkg and the waveform_column_peak_rms RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS = wcpr_pkg::SAMPLE_BITS;
	localparam int COUNT_BITS = wcpr_pkg::COUNT_BITS;
	localparam int HEIGHT_BITS = wcpr_pkg::HEIGHT_BITS;
	localparam int COLUMN_BITS = wcpr_pkg::COLUMN_BITS;
	localparam int CFG_DATA_BITS = wcpr_pkg::CFG_DATA_BITS;
	typedef wcpr_pkg::sample_t sample_t;
	typedef wcpr_pkg::result_t result_t;
	typedef wcpr_pkg::cfg_index_t cfg_index_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 100;
	localparam int REPORT_LIMIT = 10;
	localparam longint FULL = longint'(1) << (SAMPLE_BITS - 1);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	sample_t sample_data = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_index_t cfg_index = wcpr_pkg::CFG_SAMPLES_PER_COLUMN;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// register copies, at their reset values
	logic [COUNT_BITS-1:0] spc_reg = COUNT_BITS'(1);
	logic [HEIGHT_BITS-1:0] height_reg = HEIGHT_BITS'(256);
	logic [COLUMN_BITS-1:0] first_reg = '0;
	logic [COLUMN_BITS-1:0] last_reg = '1;

	// column accumulators of the prediction
	int fold_count = 0;
	logic [COLUMN_BITS-1:0] fold_column = '0;
	int fold_max = 0;
	int fold_min = 0;
	longint unsigned fold_squares = 0;
	bit past_last = 1'b1;

	result_t pending_columns[$];
	int fault_count = 0;
	int samples_taken = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit gaps_on = 1'b1;

	waveform_column_peak_rms dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_data(sample_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// height * num / (2 * FULL), clipped to the height
	function automatic logic [HEIGHT_BITS-1:0] row_for(input longint unsigned num);
		longint unsigned r;
		r = (64'(height_reg) * num) / (2 * FULL);
		if (r > height_reg)
			r = height_reg;
		return r[HEIGHT_BITS-1:0];
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			2: return SAMPLE_BITS'(int'($urandom_range(0, 32)) - 16);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic void clear_column();
		fold_count = 0;
		fold_max = 0;
		fold_min = 0;
		fold_squares = 0;
	endfunction

	task automatic fold_sample(input sample_t w);
		int s;
		longint unsigned span, mean, root, trial;
		result_t r;
		samples_taken++;
		s = int'($signed(w.sample));
		span = (spc_reg == '0) ? 1 : spc_reg;
		if (w.start_req) begin
			clear_column();
			fold_column = first_reg;
			past_last = first_reg > last_reg;
		end
		if (past_last)
			return;
		if (s > fold_max)
			fold_max = s;
		else if (s < fold_min)
			fold_min = s;
		fold_squares = fold_squares + longint'(s) * longint'(s);
		fold_count++;
		if (fold_count < span)
			return;
		mean = fold_squares / span;
		root = 0;
		for (int b = 16; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= mean)
				root = trial;
		end
		r.column = fold_column;
		r.peak_top_y = row_for(FULL - fold_max);
		r.peak_bottom_y = row_for(FULL - fold_min);
		r.rms_top_y = row_for(FULL - root);
		r.rms_bottom_y = row_for(FULL + root);
		pending_columns.push_back(r);
		clear_column();
		if (fold_column == last_reg)
			past_last = 1'b1;
		else
			fold_column = fold_column + 1'b1;
	endtask

	// returns at the edge that took the word; valid stays up for the next call
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic start);
		sample_t w;
		w.sample = value;
		w.start_req = start;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_data <= w;
		do begin
			@(posedge clk);
		end while (sample_stall);
		fold_sample(w);
	endtask

	task automatic hold_samples();
		sample_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (pending_columns.size() != 0);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			wcpr_pkg::CFG_SAMPLES_PER_COLUMN: spc_reg = value;
			wcpr_pkg::CFG_PIXEL_HEIGHT: height_reg = value[HEIGHT_BITS-1:0];
			wcpr_pkg::CFG_FIRST_COLUMN: first_reg = value[COLUMN_BITS-1:0];
			wcpr_pkg::CFG_LAST_COLUMN: last_reg = value[COLUMN_BITS-1:0];
			default: begin
			end
		endcase
	endtask

	// drain, let the back end settle, then write all four registers
	task automatic load_settings(input logic [COUNT_BITS-1:0] spc,
			input logic [HEIGHT_BITS-1:0] h,
			input logic [COLUMN_BITS-1:0] first, input logic [COLUMN_BITS-1:0] last);
		hold_samples();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(wcpr_pkg::CFG_SAMPLES_PER_COLUMN, spc);
		// upper bits of the narrow registers are junk and must be dropped
		write_reg(wcpr_pkg::CFG_PIXEL_HEIGHT, {4'($urandom), h});
		write_reg(wcpr_pkg::CFG_FIRST_COLUMN, {4'($urandom), first});
		write_reg(wcpr_pkg::CFG_LAST_COLUMN, {4'($urandom), last});
		cfg_valid <= 1'b0;
	endtask

	task automatic check_reset_defaults();
		// dropped until a start word arrives
		send_sample(16'sd1234, 1'b0);
		send_sample(-16'sd5, 1'b0);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(-16'sd1, 1'b0);
	endtask

	task automatic check_scaling();
		// zero samples per column acts as one; zero height flattens every row
		load_settings(16'd0, 12'd0, 12'd5, 12'hFFF);
		send_sample(16'sd12345, 1'b1);
		send_sample(-16'sd7, 1'b0);
		load_settings(16'd2, 12'hFFF, 12'd6, 12'hFFF);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sd1, 1'b0);
		send_sample(16'sd1, 1'b0);
		load_settings(16'd1, 12'd1, 12'd0, 12'd10);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
	endtask

	task automatic check_column_range();
		// start lands beyond the end: stays idle
		load_settings(16'd1, 12'd256, 12'hFFF, 12'hFFE);
		send_sample(16'sd100, 1'b1);
		send_sample(16'sd200, 1'b0);
		load_settings(16'd1, 12'd256, 12'hFFF, 12'hFFF);
		send_sample(16'sd5, 1'b1);
		send_sample(16'sd6, 1'b0);
		// restart in mid column, then run past the last column
		load_settings(16'd3, 12'hFFF, 12'd0, 12'd0);
		send_sample(-16'sd20000, 1'b1);
		send_sample(16'sd300, 1'b0);
		send_sample(16'sd31000, 1'b1);
		send_sample(-16'sd2, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sd77, 1'b0);
	endtask

	task automatic check_random_phases(input int target);
		logic [COUNT_BITS-1:0] spc;
		logic [HEIGHT_BITS-1:0] h;
		int first, last, run;
		while (samples_taken < target) begin
			case ($urandom_range(0, 9))
				0: spc = '0;
				1, 2: spc = COUNT_BITS'($urandom_range(7, 40));
				default: spc = COUNT_BITS'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 6))
				0: h = '0;
				1: h = 12'd1;
				2: h = '1;
				default: h = HEIGHT_BITS'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: first = 0;
				1: first = 4095;
				default: first = $urandom_range(0, 4095);
			endcase
			case ($urandom_range(0, 7))
				0: last = 4095;
				1: last = (first > 0) ? first - 1 : 0;
				default: begin
					last = first + int'($urandom_range(0, 40));
					if (last > 4095)
						last = 4095;
				end
			endcase
			load_settings(spc, h, COLUMN_BITS'(first), COLUMN_BITS'(last));
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) send_sample(pick_sample(), 1'b0);
			send_sample(pick_sample(), 1'b1);
			run = $urandom_range(10, 60);
			for (int i = 0; i < run; i++) begin
				if (i == run / 2 && $urandom_range(0, 3) == 0) begin
					hold_samples();
					wait_drained();
				end
				send_sample(pick_sample(), $urandom_range(0, 29) == 0);
			end
		end
	endtask

	task automatic check_full_scale_column();
		logic signed [SAMPLE_BITS-1:0] s;
		gaps_on = 1'b1;
		load_settings(16'd40, '1, 12'd200, 12'd200);
		send_sample(16'sh8000, 1'b1);
		// mostly full scale to push the square sum and the root to their top
		for (int i = 1; i < 40; i++) begin
			if ($urandom_range(0, 3) == 0)
				s = pick_sample();
			else
				s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			send_sample(s, 1'b0);
		end
		send_sample(pick_sample(), 1'b0);
	endtask

	task automatic check_final_stream(input int count);
		gaps_on = 1'b0;
		load_settings(COUNT_BITS'($urandom_range(1, 4)), HEIGHT_BITS'($urandom), 12'd0, '1);
		send_sample(pick_sample(), 1'b1);
		repeat (count - 1) send_sample(pick_sample(), 1'b0);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			result_stall <= 1'b1;
			stall_left = $urandom_range(0, 6);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_words
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_columns.size() == 0) begin
				if (fault_count < REPORT_LIMIT)
					$display("unexpected column word: column %0d", result_data.column);
				fault_count++;
			end else begin
				want = pending_columns.pop_front();
				if (result_data.column !== want.column ||
						result_data.peak_top_y !== want.peak_top_y ||
						result_data.peak_bottom_y !== want.peak_bottom_y ||
						result_data.rms_top_y !== want.rms_top_y ||
						result_data.rms_bottom_y !== want.rms_bottom_y) begin
					if (fault_count < REPORT_LIMIT)
						$display({"column word mismatch: expected %0d %0d %0d %0d %0d,",
							" got %0d %0d %0d %0d %0d"},
							want.column, want.peak_top_y, want.peak_bottom_y,
							want.rms_top_y, want.rms_bottom_y,
							result_data.column, result_data.peak_top_y,
							result_data.peak_bottom_y,
							result_data.rms_top_y, result_data.rms_bottom_y);
					fault_count++;
				end
			end
		end
	end

	// stop a hung run: count cycles in which no word moves on any channel
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		check_reset_defaults();
		check_scaling();
		check_column_range();
		check_random_phases(850);
		check_full_scale_column();
		check_final_stream(150);
		hold_samples();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
